### hdl/felr_pkg.sv
// felr_pkg: shared types and constants of the filtered event log ring.
// Word structs, opcodes, register indexes, controller states and commands.
// No dependencies.
package felr_pkg;

  // Ring storage and field widths
  localparam int DEPTH       = 16;
  localparam int IDX_W       = 4;
  localparam int CNT_W       = 5;
  localparam int TYPE_W      = 5;
  localparam int STAMP_BITS  = 32;
  localparam int NUM_TYPES   = 31;
  localparam int CFG_ADDR_W  = 2;
  localparam int CFG_DATA_W  = 32;

  // Register indexes on the configuration port
  localparam logic [CFG_ADDR_W-1:0] REG_GLOBAL_ENABLE = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_TYPE_MASK     = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_SIZE_IN_USE   = 2'd2;

  // Item opcodes
  typedef enum logic [1:0] {
    OP_CREATE   = 2'd0,
    OP_LATEST   = 2'd1,
    OP_PREVIOUS = 2'd2,
    OP_RESET    = 2'd3
  } felr_op_t;

  // Input word
  typedef struct packed {
    logic [1:0]            opcode;
    logic [TYPE_W-1:0]     event_type;
    logic [STAMP_BITS-1:0] time_stamp;
  } felr_in_t;

  // Result word
  typedef struct packed {
    logic [TYPE_W-1:0]     entry_type;
    logic [STAMP_BITS-1:0] entry_time;
    logic [CNT_W-1:0]      remaining;
    logic [CNT_W-1:0]      stored_count;
    logic                  logged;
  } felr_out_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_RESP
  } felr_state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;   // capture the input word
    logic exec;   // apply the word to pointers and ring
    logic read;   // read the slot under the cursor
  } felr_cmd_t;

endpackage

### hdl/filtered_event_log_ring.sv
// filtered_event_log_ring: top level of the filtered event log ring.
// Joins the controller felr_ctrl and the datapath felr_dp; types from felr_pkg.
// Depends on felr_pkg, felr_ctrl, felr_dp.
//
//  channel   ports                              handshake
//  --------  ---------------------------------  ------------------------------
//  input     item                               taken when start && !busy
//  result    result                             valid for one cycle with done
//  config    cfg_wr_en, cfg_addr, cfg_wdata     written when cfg_wr_en is high
//
// Each word passes through capture, pointer update with ring write,
// registered ring read and result strobe before another word is taken.
// done is high in ST_RESP, after ST_EXEC and ST_READ; busy is high
// from the accepting edge until done falls.
// Reset restores the register defaults and empties the log; no clearing pass.
// The receiver cannot stall: each result is shown for exactly one cycle.
module filtered_event_log_ring (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  felr_pkg::felr_in_t                item,
  output logic                              done,
  output felr_pkg::felr_out_t               result,
  input  logic                              cfg_wr_en,
  input  logic [felr_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [felr_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  felr_pkg::felr_cmd_t cmd;

  // Sequencer
  felr_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  // Registers, pointers and ring
  felr_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .item      (item),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .result    (result)
  );

endmodule

### hdl/felr_ctrl.sv
// felr_ctrl: controller state machine of the filtered event log ring.
// Sequences load, update, ring read and result strobe for each word.
// Depends on felr_pkg.
module felr_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  output logic                done,
  output felr_pkg::felr_cmd_t cmd
);

  felr_pkg::felr_state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= felr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      felr_pkg::ST_IDLE: begin
        if (start) state_next = felr_pkg::ST_EXEC;
      end
      felr_pkg::ST_EXEC: state_next = felr_pkg::ST_READ;
      felr_pkg::ST_READ: state_next = felr_pkg::ST_RESP;
      felr_pkg::ST_RESP: state_next = felr_pkg::ST_IDLE;
      default:           state_next = felr_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    done = 1'b0;
    unique case (state)
      felr_pkg::ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      felr_pkg::ST_EXEC: cmd.exec = 1'b1;
      felr_pkg::ST_READ: cmd.read = 1'b1;
      felr_pkg::ST_RESP: done = 1'b1;
      default:           busy = 1'b1;
    endcase
  end

  // An accepted word leaves the block busy next cycle
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted word did not raise busy");

  // Result strobe lasts one cycle
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for more than one cycle");

  // Strobe comes after the ST_EXEC and ST_READ states that follow acceptance
  a_done_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> ##2 done)
    else $error("result strobe out of sequence");

endmodule

### hdl/felr_dp.sv
// felr_dp: datapath of the filtered event log ring.
// Config registers, ring pointers and counters, and the type/time ring memory.
// Depends on felr_pkg.
module felr_dp (
  input  logic                                 clk,
  input  logic                                 rst,
  input  felr_pkg::felr_cmd_t                  cmd,
  input  felr_pkg::felr_in_t                   item,
  input  logic                                 cfg_wr_en,
  input  logic [felr_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [felr_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  output felr_pkg::felr_out_t                  result
);

  localparam int IW = felr_pkg::IDX_W;
  localparam int CW = felr_pkg::CNT_W;

  // Configuration
  logic                  global_enable;
  logic [31:0]           type_mask;
  logic [CW-1:0]         ring_size;     // already clamped to 1..DEPTH

  // Ring pointers and counters
  logic [IW-1:0]         write_index, write_index_next;
  logic [CW-1:0]         fill_count,  fill_count_next;
  logic [IW-1:0]         read_cursor, read_cursor_next;
  logic [CW-1:0]         iter_left,   iter_left_next;
  logic                  logged,      logged_next;

  // Captured word and ring read data
  felr_pkg::felr_in_t            item_q;
  logic [felr_pkg::TYPE_W-1:0]   rd_type;
  logic [felr_pkg::STAMP_BITS-1:0] rd_time;

  // Ring memory
  logic [felr_pkg::TYPE_W-1:0]     type_store [felr_pkg::DEPTH];
  logic [felr_pkg::STAMP_BITS-1:0] time_store [felr_pkg::DEPTH];

  logic          type_ok;
  logic          do_log;
  logic [IW-1:0] last_slot;
  logic [CW-1:0] size_wr;
  logic [4:0]    size_raw;

  // Clamp a written ring size into 1..DEPTH
  assign size_raw = cfg_wdata[4:0];
  always_comb begin
    priority if (size_raw == 5'd0) begin
      size_wr = CW'(1);
    end else if ({1'b0, size_raw} > 6'(felr_pkg::DEPTH)) begin
      size_wr = CW'(felr_pkg::DEPTH);
    end else begin
      size_wr = size_raw;
    end
  end

  // Type filter and ring size minus one
  assign type_ok = (item_q.event_type != '0) &&
                   ({1'b0, item_q.event_type} <= 6'(felr_pkg::NUM_TYPES)) &&
                   type_mask[item_q.event_type];
  assign do_log    = global_enable && type_ok;
  assign last_slot = IW'(ring_size - CW'(1));

  // Pointer update for one word
  always_comb begin
    write_index_next = write_index;
    fill_count_next  = fill_count;
    read_cursor_next = read_cursor;
    iter_left_next   = iter_left;
    logged_next      = 1'b0;
    unique case (felr_pkg::felr_op_t'(item_q.opcode))
      felr_pkg::OP_CREATE: begin
        if (do_log) begin
          logged_next = 1'b1;
          if ((CW'(write_index) + CW'(1)) >= ring_size) begin
            write_index_next = '0;
          end else begin
            write_index_next = write_index + IW'(1);
          end
          if (fill_count < ring_size) fill_count_next = fill_count + CW'(1);
        end
      end
      felr_pkg::OP_LATEST: begin
        if (fill_count != '0) begin
          read_cursor_next = (write_index == '0) ? last_slot : write_index - IW'(1);
        end else begin
          read_cursor_next = '0;
        end
        iter_left_next = fill_count;
      end
      felr_pkg::OP_PREVIOUS: begin
        if (iter_left != '0) begin
          iter_left_next   = iter_left - CW'(1);
          read_cursor_next = (read_cursor == '0) ? last_slot : read_cursor - IW'(1);
        end
      end
      felr_pkg::OP_RESET: begin
        read_cursor_next = '0;
        iter_left_next   = '0;
      end
      default: logged_next = 1'b0;
    endcase
  end

  // Control registers: config writes must only arrive while idle; the block does not enforce it
  always_ff @(posedge clk) begin
    if (rst) begin
      global_enable <= 1'b1;
      type_mask     <= '1;
      ring_size     <= CW'(felr_pkg::DEPTH);
      write_index   <= '0;
      fill_count    <= '0;
      read_cursor   <= '0;
      iter_left     <= '0;
      logged        <= 1'b0;
    end else begin
      if (cmd.exec) begin
        write_index <= write_index_next;
        fill_count  <= fill_count_next;
        read_cursor <= read_cursor_next;
        iter_left   <= iter_left_next;
        logged      <= logged_next;
      end
      if (cfg_wr_en) begin
        unique case (cfg_addr)
          felr_pkg::REG_GLOBAL_ENABLE: global_enable <= cfg_wdata[0];
          felr_pkg::REG_TYPE_MASK:     type_mask     <= cfg_wdata[31:0];
          felr_pkg::REG_SIZE_IN_USE: begin
            // new size empties the log
            ring_size   <= size_wr;
            write_index <= '0;
            fill_count  <= '0;
            read_cursor <= '0;
            iter_left   <= '0;
          end
          default: global_enable <= global_enable;
        endcase
      end
    end
  end

  // Word capture
  always_ff @(posedge clk) begin
    if (cmd.load) item_q <= item;
  end

  // Ring write on a logged create
  always_ff @(posedge clk) begin
    if (cmd.exec && do_log &&
        (felr_pkg::felr_op_t'(item_q.opcode) == felr_pkg::OP_CREATE)) begin
      type_store[write_index] <= item_q.event_type;
      time_store[write_index] <= item_q.time_stamp;
    end
  end

  // Ring read at the updated cursor
  always_ff @(posedge clk) begin
    if (cmd.read) begin
      rd_type <= type_store[read_cursor];
      rd_time <= time_store[read_cursor];
    end
  end

  // Result word
  assign result.entry_type   = rd_type;
  assign result.entry_time   = rd_time;
  assign result.remaining    = iter_left;
  assign result.stored_count = fill_count;
  assign result.logged       = logged;

  // Pointers stay inside the ring in use
  a_index_range: assert property (@(posedge clk) disable iff (rst)
    (CW'(write_index) < ring_size) && (CW'(read_cursor) < ring_size))
    else $error("ring index outside ring size");

  // Counts never exceed the ring size and iteration never outruns the fill
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    (fill_count <= ring_size) && (iter_left <= fill_count))
    else $error("count outside its bounds");

  // Size write empties the log
  a_size_clear: assert property (@(posedge clk) disable iff (rst)
    (cfg_wr_en && (cfg_addr == felr_pkg::REG_SIZE_IN_USE)) |=>
      (fill_count == '0) && (iter_left == '0) && (write_index == '0))
    else $error("size write did not empty the log");

endmodule

### test/tb_filtered_event_log_ring.sv
`timescale 1ns / 100ps
// tb_filtered_event_log_ring: self-checking bench for the filtered event log ring.
// Sends event and iteration words, changes registers between phases and checks each result
// against a behavioral copy of the log. Depends on felr_pkg and filtered_event_log_ring.
module tb_filtered_event_log_ring;

  localparam int CYCLE_LIMIT = 200000;
  localparam int MAX_SHOWN   = 10;
  localparam int PHASE_WORDS = 75;

  // Behavioral copy of the log and the queue of predicted results
  class event_log_scoreboard;
    bit                              log_on;
    logic [31:0]                     type_mask;
    logic [felr_pkg::CNT_W-1:0]      size_reg;
    logic [felr_pkg::TYPE_W-1:0]     type_mem [felr_pkg::DEPTH];
    logic [felr_pkg::STAMP_BITS-1:0] stamp_mem [felr_pkg::DEPTH];
    bit   [felr_pkg::DEPTH-1:0]      slot_written;
    int                              wr_idx, fill, cursor, left;
    felr_pkg::felr_out_t             predicted_q [$];
    int                              mismatches, checked, stored_seen;

    function new();
      log_on       = 1'b1;
      type_mask    = '1;
      size_reg     = felr_pkg::CNT_W'(felr_pkg::DEPTH);
      slot_written = '0;
      wr_idx       = 0;
      fill         = 0;
      cursor       = 0;
      left         = 0;
      mismatches   = 0;
      checked      = 0;
      stored_seen  = 0;
    endfunction

    function void write_reg(logic [felr_pkg::CFG_ADDR_W-1:0] addr,
                            logic [felr_pkg::CFG_DATA_W-1:0] data);
      case (addr)
        felr_pkg::REG_GLOBAL_ENABLE: log_on = data[0];
        felr_pkg::REG_TYPE_MASK:     type_mask = data;
        felr_pkg::REG_SIZE_IN_USE: begin
          // new size empties the log, slot contents stay
          size_reg = data[felr_pkg::CNT_W-1:0];
          wr_idx   = 0;
          fill     = 0;
          cursor   = 0;
          left     = 0;
        end
        default: ;
      endcase
    endfunction

    // Works out the result of one word; commits state only when asked.
    // Returns 0 when the result would show a slot never written.
    function bit apply_word(felr_pkg::felr_in_t w, bit commit,
                            output felr_pkg::felr_out_t r);
      int sz, nw, nf, nc, nl, slot;
      bit stored;
      sz = (size_reg == 0) ? 1 : (size_reg > felr_pkg::DEPTH) ? felr_pkg::DEPTH :
           int'(size_reg);
      nw = (wr_idx >= sz) ? 0 : wr_idx;
      nc = (cursor >= sz) ? 0 : cursor;
      nf = (fill > sz) ? sz : fill;
      nl = (left > sz) ? sz : left;
      slot   = nw;
      stored = 1'b0;
      case (felr_pkg::felr_op_t'(w.opcode))
        felr_pkg::OP_CREATE: begin
          if (log_on && w.event_type != 0 && w.event_type <= felr_pkg::NUM_TYPES &&
              type_mask[w.event_type]) begin
            stored = 1'b1;
            nw = (nw + 1 >= sz) ? 0 : nw + 1;
            if (nf < sz) nf++;
          end
        end
        felr_pkg::OP_LATEST: begin
          nc = (nf == 0) ? 0 : (nw == 0) ? sz - 1 : nw - 1;
          nl = nf;
        end
        felr_pkg::OP_PREVIOUS: begin
          if (nl > 0) begin
            nl--;
            nc = (nc == 0) ? sz - 1 : nc - 1;
          end
        end
        default: begin
          nc = 0;
          nl = 0;
        end
      endcase
      if (stored && slot == nc) begin
        r.entry_type = w.event_type;
        r.entry_time = w.time_stamp;
      end else begin
        r.entry_type = type_mem[nc];
        r.entry_time = stamp_mem[nc];
      end
      r.remaining    = felr_pkg::CNT_W'(nl);
      r.stored_count = felr_pkg::CNT_W'(nf);
      r.logged       = stored;
      apply_word = slot_written[nc] || (stored && slot == nc);
      if (commit) begin
        if (stored) begin
          type_mem[slot]     = w.event_type;
          stamp_mem[slot]    = w.time_stamp;
          slot_written[slot] = 1'b1;
        end
        wr_idx = nw;
        fill   = nf;
        cursor = nc;
        left   = nl;
      end
    endfunction

    function bit reads_written(felr_pkg::felr_in_t w);
      felr_pkg::felr_out_t r;
      return apply_word(w, 1'b0, r);
    endfunction

    // Called at the edge that accepts a word
    function void note_word(felr_pkg::felr_in_t w);
      felr_pkg::felr_out_t r;
      void'(apply_word(w, 1'b1, r));
      predicted_q.push_back(r);
    endfunction

    function void flag(string what, felr_pkg::felr_out_t exp, felr_pkg::felr_out_t got);
      mismatches++;
      if (mismatches <= MAX_SHOWN)
        $display({"mismatch (%s): expected type %0d time %h rem %0d cnt %0d logged %0d,",
                  " got type %0d time %h rem %0d cnt %0d logged %0d"},
                 what, exp.entry_type, exp.entry_time, exp.remaining, exp.stored_count,
                 exp.logged, got.entry_type, got.entry_time, got.remaining,
                 got.stored_count, got.logged);
    endfunction

    function void check_result(felr_pkg::felr_out_t got);
      felr_pkg::felr_out_t exp;
      string bad;
      bad = "";
      if (predicted_q.size() == 0) begin
        flag("result with nothing predicted", '0, got);
        return;
      end
      exp = predicted_q.pop_front();
      checked++;
      if (exp.logged) stored_seen++;
      if (got.entry_type !== exp.entry_type) bad = {bad, " entry_type"};
      if (got.entry_time !== exp.entry_time) bad = {bad, " entry_time"};
      if (got.remaining !== exp.remaining) bad = {bad, " remaining"};
      if (got.stored_count !== exp.stored_count) bad = {bad, " stored_count"};
      if (got.logged !== exp.logged) bad = {bad, " logged"};
      if (bad != "") flag(bad, exp, got);
    endfunction

    function int outstanding();
      return predicted_q.size();
    endfunction

    function void close_out();
      if (predicted_q.size() != 0) begin
        mismatches++;
        $display("%0d predicted results never arrived", predicted_q.size());
      end
    endfunction
  endclass

  logic                            clk;
  logic                            rst;
  logic                            start;
  logic                            busy;
  felr_pkg::felr_in_t              item;
  logic                            done;
  felr_pkg::felr_out_t             result;
  logic                            cfg_wr_en;
  logic [felr_pkg::CFG_ADDR_W-1:0] cfg_addr;
  logic [felr_pkg::CFG_DATA_W-1:0] cfg_wdata;

  event_log_scoreboard sb;
  int  words_sent    = 0;
  int  settings_used = 0;
  int  cycle_count   = 0;
  bit  idle_ok       = 1'b0;

  filtered_event_log_ring dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .item      (item),
    .done      (done),
    .result    (result),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result monitor and run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAILED: results differ");
      $finish;
    end
    if (!rst && done === 1'b1) sb.check_result(result);
  end

  function automatic felr_pkg::felr_in_t word_of(felr_pkg::felr_op_t op, int etype,
                                                 logic [31:0] stamp);
    felr_pkg::felr_in_t w;
    w.opcode     = op;
    w.event_type = felr_pkg::TYPE_W'(etype);
    w.time_stamp = stamp;
    return w;
  endfunction

  function automatic felr_pkg::felr_in_t rand_word(felr_pkg::felr_op_t op);
    return word_of(op, $urandom_range(0, 31), $urandom);
  endfunction

  // Hands one word over; words that would show an unwritten slot are dropped
  task automatic send_word(felr_pkg::felr_in_t w);
    if (!sb.reads_written(w)) return;
    if (idle_ok && $urandom_range(0, 99) < 12) begin
      @(negedge clk);
      start = 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    @(negedge clk);
    start = 1'b1;
    item  = w;
    do @(posedge clk); while (busy !== 1'b0);
    sb.note_word(w);
    words_sent++;
  endtask

  // Stop sending and wait until every predicted result is in
  task automatic drain();
    @(negedge clk);
    start = 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [felr_pkg::CFG_ADDR_W-1:0] addr,
                           logic [felr_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_addr  = addr;
    cfg_wdata = data;
    @(posedge clk);
    sb.write_reg(addr, data);
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  task automatic change_reg(logic [felr_pkg::CFG_ADDR_W-1:0] addr,
                            logic [felr_pkg::CFG_DATA_W-1:0] data);
    drain();
    write_reg(addr, data);
    settings_used++;
  endtask

  task automatic set_regs(bit on, logic [31:0] mask, logic [felr_pkg::CNT_W-1:0] sz);
    logic [felr_pkg::CFG_DATA_W-1:0] data;
    drain();
    // unused upper bits carry noise
    data    = $urandom;
    data[0] = on;
    write_reg(felr_pkg::REG_GLOBAL_ENABLE, data);
    write_reg(felr_pkg::REG_TYPE_MASK, mask);
    data = $urandom;
    data[felr_pkg::CNT_W-1:0] = sz;
    write_reg(felr_pkg::REG_SIZE_IN_USE, data);
    settings_used++;
  endtask

  // Mostly fill / jump to newest / walk back, with loose words mixed in
  task automatic run_phase(int n);
    int target;
    target = words_sent + n;
    while (words_sent < target) begin
      if ($urandom_range(0, 9) < 7) begin
        repeat ($urandom_range(0, 20)) send_word(rand_word(felr_pkg::OP_CREATE));
        send_word(rand_word(felr_pkg::OP_LATEST));
        repeat ($urandom_range(0, 18))
          send_word(rand_word(($urandom_range(0, 9) == 0) ? felr_pkg::OP_CREATE :
                                                            felr_pkg::OP_PREVIOUS));
      end else begin
        send_word(rand_word(felr_pkg::felr_op_t'($urandom_range(0, 3))));
      end
    end
  endtask

  initial begin
    logic [31:0] mask;
    int          sizes [8];
    sizes = '{16, 1, 16, 5, 31, 0, 3, 17};
    sb        = new();
    rst       = 1'b1;
    start     = 1'b0;
    item      = '0;
    cfg_wr_en = 1'b0;
    cfg_addr  = felr_pkg::REG_GLOBAL_ENABLE;
    cfg_wdata = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: defaults, extremes of type and stamp, end of walk
    send_word(word_of(felr_pkg::OP_CREATE, 1, 32'h0000_0000));
    send_word(word_of(felr_pkg::OP_CREATE, felr_pkg::NUM_TYPES, 32'hFFFF_FFFF));
    send_word(word_of(felr_pkg::OP_CREATE, 0, 32'h1234_5678));
    send_word(word_of(felr_pkg::OP_LATEST, 0, 32'h0));
    send_word(word_of(felr_pkg::OP_PREVIOUS, 0, 32'h0));
    send_word(word_of(felr_pkg::OP_RESET, 0, 32'h0));
    send_word(word_of(felr_pkg::OP_PREVIOUS, 0, 32'h0));

    // logging switched off
    change_reg(felr_pkg::REG_GLOBAL_ENABLE, 32'hFFFF_FFFE);
    send_word(word_of(felr_pkg::OP_CREATE, 7, 32'hA5A5_A5A5));
    send_word(word_of(felr_pkg::OP_LATEST, 0, 32'h0));

    // type 5 masked out
    change_reg(felr_pkg::REG_GLOBAL_ENABLE, 32'h0000_0001);
    change_reg(felr_pkg::REG_TYPE_MASK, 32'hFFFF_FFDF);
    send_word(word_of(felr_pkg::OP_CREATE, 5, 32'h5555_5555));
    send_word(word_of(felr_pkg::OP_CREATE, 6, 32'hAAAA_AAAA));

    // single-slot ring, then size 0 read as 1
    change_reg(felr_pkg::REG_TYPE_MASK, 32'hFFFF_FFFF);
    change_reg(felr_pkg::REG_SIZE_IN_USE, 32'd1);
    send_word(word_of(felr_pkg::OP_CREATE, 2, 32'h0000_0002));
    send_word(word_of(felr_pkg::OP_CREATE, 3, 32'h0000_0003));
    send_word(word_of(felr_pkg::OP_LATEST, 0, 32'h0));
    send_word(word_of(felr_pkg::OP_PREVIOUS, 0, 32'h0));
    change_reg(felr_pkg::REG_SIZE_IN_USE, 32'd0);
    send_word(word_of(felr_pkg::OP_CREATE, 4, 32'h0000_0004));

    // oversize read as full depth; latest on an empty log
    change_reg(felr_pkg::REG_SIZE_IN_USE, 32'd31);
    send_word(word_of(felr_pkg::OP_LATEST, 0, 32'h0));
    send_word(word_of(felr_pkg::OP_CREATE, 9, 32'h0000_0009));
    send_word(word_of(felr_pkg::OP_LATEST, 0, 32'h0));

    // two-slot ring wrapping over its oldest entry
    change_reg(felr_pkg::REG_SIZE_IN_USE, 32'd2);
    send_word(word_of(felr_pkg::OP_CREATE, 10, 32'h0000_000A));
    send_word(word_of(felr_pkg::OP_CREATE, 11, 32'h0000_000B));
    send_word(word_of(felr_pkg::OP_CREATE, 12, 32'h0000_000C));
    send_word(word_of(felr_pkg::OP_LATEST, 0, 32'h0));
    send_word(word_of(felr_pkg::OP_PREVIOUS, 0, 32'h0));
    send_word(word_of(felr_pkg::OP_PREVIOUS, 0, 32'h0));

    // Random phases, one register setting each
    for (int p = 0; p < 8; p++) begin
      mask = (p == 0 || p == 6) ? 32'hFFFF_FFFF : (p == 4) ? 32'h0 : ($urandom | $urandom);
      set_regs(p != 3, mask, felr_pkg::CNT_W'(sizes[p]));
      idle_ok = (p != 2);
      // fill the whole ring once so every slot holds data
      if (p == 0)
        for (int k = 0; k < felr_pkg::DEPTH; k++)
          send_word(word_of(felr_pkg::OP_CREATE, 1 + k, $urandom));
      run_phase(PHASE_WORDS);
    end

    drain();
    repeat (8) @(posedge clk);
    sb.close_out();
    $display("Ran %0d words over %0d register settings (ring sizes 1 to %0d).",
             words_sent, settings_used, felr_pkg::DEPTH);
    $display("Checked %0d results, %0d of them newly stored events; %0d mismatches.",
             sb.checked, sb.stored_seen, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
